FILE: sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types, constants and the microcode of the line editor
// Holds character codes, result kinds, the control word layout, the
// read-only microprogram and the entry decode that picks a routine per byte.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UPC_W  = 4;

  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2,
    KIND_OVF  = 2'd3
  } kind_t;

  // Source of the data byte of an emitted result.
  typedef enum logic [2:0] {
    DS_BS   = 3'd0,
    DS_SP   = 3'd1,
    DS_CR   = 3'd2,
    DS_LF   = 3'd3,
    DS_RX   = 3'd4,
    DS_RDQ  = 3'd5,
    DS_LEN  = 3'd6,
    DS_ZERO = 3'd7
  } dsel_t;

  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram addresses (routine entries and their follow-on steps).
  localparam upc_t UA_BS_ECHO  = 4'd0;
  localparam upc_t UA_BS_SP    = 4'd1;
  localparam upc_t UA_BS_LAST  = 4'd2;
  localparam upc_t UA_BS_QUIET = 4'd3;
  localparam upc_t UA_CLR_JE   = 4'd4;
  localparam upc_t UA_OVF      = 4'd5;
  localparam upc_t UA_ST_ECHO  = 4'd6;
  localparam upc_t UA_ST_QUIET = 4'd7;
  localparam upc_t UA_SW_CR    = 4'd8;
  localparam upc_t UA_SW_LF    = 4'd9;
  localparam upc_t UA_TM_CR    = 4'd10;
  localparam upc_t UA_TM_LF    = 4'd11;
  localparam upc_t UA_LOOP     = 4'd12;
  localparam upc_t UA_END      = 4'd13;

  // One control word. A guarded step repeats while the read pointer is
  // below the line length, and is skipped with no effect once it is not.
  typedef struct packed {
    logic  emit;
    kind_t kind;
    dsel_t dsel;
    logic  last;
    logic  st;
    logic  dec;
    logic  clr_len;
    logic  set_je;
    logic  clr_je;
    logic  guard;
    logic  done;
  } ucw_t;

  // Sequencer to datapath: qualified actions for this cycle.
  typedef struct packed {
    logic  accept;
    logic  emit;
    kind_t kind;
    dsel_t dsel;
    logic  last;
    logic  st;
    logic  dec;
    logic  clr_len;
    logic  set_je;
    logic  clr_je;
    logic  ptr_inc;
    logic  ptr_clr;
  } ctrl_t;

  // Datapath to sequencer: conditions for dispatch, branching and stalls.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             len_zero;
    logic             at_limit;
    logic             ptr_lt_len;
    logic             just_ended;
    logic             out_free;
  } stat_t;

  function automatic ucw_t uw(input logic emit, input kind_t kind, input dsel_t dsel,
                              input logic last, input logic st, input logic dec,
                              input logic clr_len, input logic set_je, input logic clr_je,
                              input logic guard, input logic done);
    ucw_t w;
    w.emit = emit; w.kind = kind; w.dsel = dsel; w.last = last; w.st = st;
    w.dec = dec; w.clr_len = clr_len; w.set_je = set_je; w.clr_je = clr_je;
    w.guard = guard; w.done = done;
    return w;
  endfunction

  // The microprogram.
  function automatic ucw_t tle_rom(input upc_t pc);
    ucw_t w;
    case (pc)
      //                      emit  kind       dsel     last st   dec  clrl setj clrj grd  done
      UA_BS_ECHO:  w = uw(1'b1, KIND_ECHO, DS_BS,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      UA_BS_SP:    w = uw(1'b1, KIND_ECHO, DS_SP,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      UA_BS_LAST:  w = uw(1'b1, KIND_ECHO, DS_BS,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      UA_BS_QUIET: w = uw(1'b0, KIND_ECHO, DS_ZERO, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_CLR_JE:   w = uw(1'b0, KIND_ECHO, DS_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_OVF:      w = uw(1'b1, KIND_OVF,  DS_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_ST_ECHO:  w = uw(1'b1, KIND_ECHO, DS_RX,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_ST_QUIET: w = uw(1'b0, KIND_ECHO, DS_ZERO, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_SW_CR:    w = uw(1'b1, KIND_ECHO, DS_CR,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      UA_SW_LF:    w = uw(1'b1, KIND_ECHO, DS_LF,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      UA_TM_CR:    w = uw(1'b1, KIND_ECHO, DS_CR,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      UA_TM_LF:    w = uw(1'b1, KIND_ECHO, DS_LF,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      UA_LOOP:     w = uw(1'b1, KIND_LINE, DS_RDQ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      UA_END:      w = uw(1'b1, KIND_END,  DS_LEN,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
      default:     w = uw(1'b0, KIND_ECHO, DS_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  // Picks the routine for a freshly accepted byte from the current state.
  function automatic upc_t tle_entry(input logic [BYTE_W-1:0] rx, input logic echo,
                                     input stat_t s);
    upc_t pc;
    if (rx == CH_BS) begin
      if (s.len_zero) pc = UA_CLR_JE;
      else            pc = echo ? UA_BS_ECHO : UA_BS_QUIET;
    end else if (rx == CH_CR || rx == CH_LF) begin
      if (s.just_ended) pc = (rx == CH_CR && echo) ? UA_SW_CR : UA_CLR_JE;
      else              pc = (rx == CH_CR && echo) ? UA_TM_CR : UA_LOOP;
    end else begin
      if (s.at_limit) pc = UA_OVF;
      else            pc = echo ? UA_ST_ECHO : UA_ST_QUIET;
    end
    return pc;
  endfunction

endpackage

FILE: sv/tle_useq.sv
// ----------------------------------------------------------------------------
// tle_useq: microcode sequencer
// Holds the step counter, dispatches on an accepted byte and walks the
// microprogram, stalling emitting steps while the output register is full.
// ----------------------------------------------------------------------------
module tle_useq
  import tle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              echo,
  input  stat_t             stat,
  output logic              busy,
  output ctrl_t             ctrl
);

  logic busy_r, busy_nxt;
  upc_t pc_r, pc_nxt;
  ucw_t ucw;
  logic accept, skip, fire;

  assign ucw    = tle_rom(pc_r);
  assign accept = in_valid && !busy_r;
  assign skip   = busy_r && ucw.guard && !stat.ptr_lt_len;
  assign fire   = busy_r && !skip && (!ucw.emit || stat.out_free);
  assign busy   = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = tle_entry(in_byte, echo, stat);
    end else if (skip) begin
      pc_nxt = pc_r + upc_t'(1);
    end else if (fire) begin
      if (ucw.done) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else if (!ucw.guard) begin
        pc_nxt = pc_r + upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  always_comb begin
    ctrl.accept  = accept;
    ctrl.emit    = fire && ucw.emit;
    ctrl.kind    = ucw.kind;
    ctrl.dsel    = ucw.dsel;
    ctrl.last    = ucw.last;
    ctrl.st      = fire && ucw.st;
    ctrl.dec     = fire && ucw.dec;
    ctrl.clr_len = fire && ucw.clr_len;
    ctrl.set_je  = fire && ucw.set_je;
    ctrl.clr_je  = fire && ucw.clr_je;
    ctrl.ptr_inc = fire && ucw.guard;
    ctrl.ptr_clr = fire && ucw.done;
  end

endmodule

FILE: sv/tle_dpath.sv
// ----------------------------------------------------------------------------
// tle_dpath: line editor datapath
// Line store memory, length and line-ended flag, read pointer with a
// registered read port, and the result output register.
// ----------------------------------------------------------------------------
module tle_dpath
  import tle_pkg::*;
#(
  parameter int unsigned MAX_LINE = 60
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [LEN_W-1:0]  limit,
  input  logic              out_ready,
  output stat_t             stat,
  output logic              out_valid,
  output kind_t             out_kind,
  output logic [BYTE_W-1:0] out_data,
  output logic              out_last
);

  localparam int unsigned IDX_W = $clog2(MAX_LINE);

  logic [BYTE_W-1:0] mem [MAX_LINE];
  logic [BYTE_W-1:0] rx_r;
  logic [BYTE_W-1:0] rd_q_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  ptr_r, ptr_nxt;
  logic              je_r, je_nxt;
  logic              ov_r, ov_nxt;
  kind_t             kind_r;
  logic [BYTE_W-1:0] data_r, data_sel;
  logic              last_r;

  always_comb begin
    len_nxt = len_r;
    if (ctrl.clr_len)  len_nxt = '0;
    else if (ctrl.st)  len_nxt = len_r + LEN_W'(1);
    else if (ctrl.dec) len_nxt = len_r - LEN_W'(1);
    je_nxt = je_r;
    if (ctrl.set_je)      je_nxt = 1'b1;
    else if (ctrl.clr_je) je_nxt = 1'b0;
    ptr_nxt = ptr_r;
    if (ctrl.ptr_clr)      ptr_nxt = '0;
    else if (ctrl.ptr_inc) ptr_nxt = ptr_r + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      je_r  <= 1'b0;
      ptr_r <= '0;
    end else begin
      len_r <= len_nxt;
      je_r  <= je_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Reading at the next pointer keeps rd_q_r equal to the entry at ptr_r.
  always_ff @(posedge clk) begin
    if (ctrl.accept) rx_r <= in_byte;
    if (ctrl.st) mem[len_r[IDX_W-1:0]] <= rx_r;
    if (ptr_nxt < LEN_W'(MAX_LINE)) rd_q_r <= mem[ptr_nxt[IDX_W-1:0]];
  end

  always_comb begin
    case (ctrl.dsel)
      DS_BS:   data_sel = CH_BS;
      DS_SP:   data_sel = CH_SP;
      DS_CR:   data_sel = CH_CR;
      DS_LF:   data_sel = CH_LF;
      DS_RX:   data_sel = rx_r;
      DS_RDQ:  data_sel = rd_q_r;
      DS_LEN:  data_sel = BYTE_W'(len_r);
      default: data_sel = '0;
    endcase
  end

  assign ov_nxt = ctrl.emit ? 1'b1 : (ov_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      kind_r <= ctrl.kind;
      data_r <= data_sel;
      last_r <= ctrl.last;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

  always_comb begin
    stat.len        = len_r;
    stat.len_zero   = (len_r == '0);
    stat.at_limit   = (len_r >= limit);
    stat.ptr_lt_len = (ptr_r < len_r);
    stat.just_ended = je_r;
    stat.out_free   = !ov_r || out_ready;
  end

endmodule

FILE: sv/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor: console line editor with echo
// Collects received bytes into a line, edits on backspace, echoes and reads
// the line out on CR or LF, followed by an end beat carrying the length.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  in_      slave      tdata[7:0] = rx_byte
//  out_     master     tdata[7:0] = data, tuser[1:0] = kind, tlast = last
//  cfg_     APB slave  0x0 echo_enable (bit 0), 0x4 max_line_length (bits 5:0)
//
// One byte is handled at a time. The sequencer dispatches on an accepted
// byte and then runs the steps of its routine: an ordinary byte has one
// step, backspace with echo three, and a terminator a readout step repeated
// once per stored byte and an end step, preceded by a CR and an LF step when
// a CR is echoed, the line readout emitting one stored byte per cycle unless
// the output stalls, from the registered read port of the line store.
// Reset is synchronous and active low; it clears the length, the line-ended
// flag, the sequencer and the output valid; the line store is not cleared.
// A stalled output register holds the sequencer on its current step; a new
// byte is taken as soon as the previous byte's last step has issued, while
// its final beat may still wait in the output register.
// ----------------------------------------------------------------------------
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int unsigned MAX_LINE = 60
)
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             echo_r;
  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W-1:0] limit;
  logic             cfg_wr;
  logic             busy;
  ctrl_t            ctrl;
  stat_t            stat;
  kind_t            out_kind;

  // Registers are word aligned; address bit 2 selects between the two.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r    <= 1'b1;
      max_len_r <= LEN_W'(32);
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) max_len_r <= cfg_pwdata[LEN_W-1:0];
      else              echo_r    <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {{(32-LEN_W){1'b0}}, max_len_r} : {31'b0, echo_r};

  // A limit above the store depth acts as the store depth.
  assign limit = (max_len_r > LEN_W'(MAX_LINE)) ? LEN_W'(MAX_LINE) : max_len_r;

  tle_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .echo     (echo_r),
    .stat     (stat),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  tle_dpath #(.MAX_LINE(MAX_LINE)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_byte   (in_tdata),
    .limit     (limit),
    .out_ready (out_tready),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_kind  (out_kind),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  assign in_tready = !busy;
  assign out_tuser = out_kind;

  // The stored length never runs past the line store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.len <= LEN_W'(MAX_LINE))
    else $error("line length beyond line store");

  // Accepting a byte starts the sequencer, which then refuses the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer did not start on an accepted byte");

  // Line end and overflow beats are always the final beat of their byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_kind == KIND_END || out_kind == KIND_OVF) |-> out_tlast)
    else $error("line end or overflow beat without last");

  // A completed line leaves an empty line behind it.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit && ctrl.kind == KIND_END |=> stat.len == '0 && stat.just_ended)
    else $error("line not cleared after line end");

endmodule
